// ===== sv/lpg_pkg.sv =====
// Shared types and constants for the line-of-sight path guidance block.
`default_nettype none
package lpg_pkg;

  typedef enum logic [1:0] {
    CFG_RADIUS    = 2'd0,
    CFG_MAX_SPEED = 2'd1,
    CFG_MIN_SPEED = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_POSE = 1'b1
  } cmd_e;

  typedef enum logic [3:0] {
    T_NONE, T_RAW, T_R2, T_L2S, T_L2A, T_DOTS, T_DOTA, T_CRS, T_CRB,
    T_WS0, T_WS1, T_WS2, T_WA0, T_WA1, T_WA2
  } mul_tag_e;

  typedef struct packed {
    logic               vld;
    mul_tag_e           tag;
    logic signed [65:0] p;
  } mul_res_t;

  localparam logic signed [17:0] PI_Q      = 18'sd25736;
  localparam logic signed [17:0] TWO_PI_Q  = 18'sd51472;
  localparam logic [15:0]        HALF_PI_Q = 16'd12868;
  localparam int unsigned        CORDIC_STEPS = 20;
  localparam logic signed [23:0] ATAN0_X2  = 24'sd1647100;
  localparam logic [63:0] SPD_RECIP =
    ((64'd1 << 44) + 64'(HALF_PI_Q) - 64'd1) / 64'(HALF_PI_Q);

  function automatic logic [21:0] cordic_atan(input logic [4:0] i);
    logic [21:0] r;
    unique case (i)
      5'd0:  r = 22'd823550;
      5'd1:  r = 22'd486170;
      5'd2:  r = 22'd256879;
      5'd3:  r = 22'd130396;
      5'd4:  r = 22'd65451;
      5'd5:  r = 22'd32757;
      5'd6:  r = 22'd16383;
      5'd7:  r = 22'd8192;
      5'd8:  r = 22'd4096;
      5'd9:  r = 22'd2048;
      5'd10: r = 22'd1024;
      5'd11: r = 22'd512;
      5'd12: r = 22'd256;
      5'd13: r = 22'd128;
      5'd14: r = 22'd64;
      5'd15: r = 22'd32;
      5'd16: r = 22'd16;
      5'd17: r = 22'd8;
      5'd18: r = 22'd4;
      5'd19: r = 22'd2;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/lpg_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module lpg_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64
) (
  input  wire logic                           clk_i,
  input  wire logic                           we_i,
  input  wire logic [$clog2(Depth)-1:0]       waddr_i,
  input  wire logic [Width-1:0]               wdata_i,
  input  wire logic                           re_i,
  input  wire logic [$clog2(Depth)-1:0]       raddr_i,
  output logic      [Width-1:0]               rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule
`default_nettype wire

// ===== sv/lpg_mul.sv =====
// Shared registered 33x33 signed multiplier with a result tag.
`default_nettype none
module lpg_mul (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               go_i,
  input  wire logic signed [32:0] a_i,
  input  wire logic signed [32:0] b_i,
  input  wire lpg_pkg::mul_tag_e  tag_i,
  output lpg_pkg::mul_res_t       res_o
);
  logic               vld_q;
  lpg_pkg::mul_tag_e  tag_q;
  logic signed [65:0] p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      tag_q <= lpg_pkg::T_NONE;
    end else begin
      vld_q <= go_i;
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign res_o = {vld_q, tag_q, p_q};
endmodule
`default_nettype wire

// ===== sv/los_path_guidance.sv =====
// Top level: line-of-sight path guidance over a stored waypoint path.
//
//  channel  | handshake        | payload
//  ---------+------------------+--------------------------------------------------
//  request  | start / busy     | command_i restart_path_i pos_x_i pos_y_i heading_i
//  result   | done_o (strobe)  | speed_o course_o path_empty_o seg_found_o
//  config   | cfg_we_i         | cfg_idx_i cfg_data_i
//
// A pose request with fewer than two points is answered from the idle state.
// Otherwise the block squares the radius, reads the first two points, then walks
// the segments (one shared multiplier, one RAM read per segment; a segment that
// fails the projection test skips the wide test), normalizes, runs the CORDIC
// steps, rounds and computes the speed. Reset clears the point count and control
// registers and restores the configuration defaults; the datapath registers and
// the waypoint RAM are not cleared. busy is high only while a pose search runs.
`default_nettype none
module los_path_guidance #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               command_i,
  input  wire logic               restart_path_i,
  input  wire logic signed [31:0] pos_x_i,
  input  wire logic signed [31:0] pos_y_i,
  input  wire logic signed [15:0] heading_i,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [30:0]        cfg_data_i,
  output logic                    done_o,
  output logic [15:0]             speed_o,
  output logic signed [15:0]      course_o,
  output logic                    path_empty_o,
  output logic                    seg_found_o
);
  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_R2    = 14'b00000000000010,
    S_LDA   = 14'b00000000000100,
    S_LDB   = 14'b00000000001000,
    S_SEG   = 14'b00000000010000,
    S_CHK   = 14'b00000000100000,
    S_WIDE  = 14'b00000001000000,
    S_WCHK  = 14'b00000010000000,
    S_ANORM = 14'b00000100000000,
    S_CORD  = 14'b00001000000000,
    S_RND   = 14'b00010000000000,
    S_SPD   = 14'b00100000000000,
    S_DIV   = 14'b01000000000000,
    S_FIN   = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [3:0]    sc_q, sc_d;
  logic [4:0]    it_q, it_d;
  logic          found_q, found_d, nz_q, nz_d, done_q, done_d;
  logic [30:0]   radius_q;
  logic [15:0]   maxs_q, mins_q;

  logic signed [31:0] ax_q, ax_d, ay_q, ay_d, px_q, px_d, py_q, py_d;
  logic signed [15:0] hd_q, hd_d, course_q, course_d;
  logic signed [30:0] dx_q, dx_d, dy_q, dy_d, vx_q, vx_d, vy_q, vy_d;
  logic signed [43:0] cx_q, cx_d, cy_q, cy_d;
  logic signed [23:0] cz_q, cz_d;
  logic [15:0]        spd_q, spd_d;
  logic signed [15:0] ocrs_q, ocrs_d;
  logic               oempty_q, oempty_d, ofound_q, ofound_d;

  logic [61:0]         l2_q, r2_q;
  logic signed [62:0]  dot_q, cr_q;
  logic signed [129:0] wa_q;
  logic                wa_clr;

  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [63:0]        ram_rdata;
  logic signed [31:0] rd_x, rd_y;

  logic               mul_go;
  logic signed [32:0] mul_a, mul_b;
  lpg_pkg::mul_tag_e  mul_tag;
  lpg_pkg::mul_res_t  mres;
  logic [129:0]       wterm;

  logic signed [32:0] dfx, dfy, dvx, dvy, tgx, tgy;
  logic signed [62:0] abs_cr;
  logic [63:0]        c4;
  logic signed [43:0] abs_x, abs_y, xs, ys;
  logic signed [24:0] rz;
  logic signed [17:0] rr, err_raw, err_w;
  logic [15:0]        err_abs;
  logic signed [15:0] spd_fac;
  logic [15:0]        quo;
  logic               seg_skip, more_seg;

  assign busy = (state_q != S_IDLE);
  assign rd_x = ram_rdata[63:32];
  assign rd_y = ram_rdata[31:0];

  lpg_ram #(.Width(64), .Depth(MAX_POINTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({pos_x_i, pos_y_i}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  lpg_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (mul_go),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .tag_i  (mul_tag),
    .res_o  (mres)
  );

  always_comb begin
    dfx      = {rd_x[31], rd_x} - {ax_q[31], ax_q};
    dfy      = {rd_y[31], rd_y} - {ay_q[31], ay_q};
    dvx      = {px_q[31], px_q} - {ax_q[31], ax_q};
    dvy      = {py_q[31], py_q} - {ay_q[31], ay_q};
    tgx      = {rd_x[31], rd_x} - {px_q[31], px_q};
    tgy      = {rd_y[31], rd_y} - {py_q[31], py_q};
    abs_cr   = cr_q[62] ? -cr_q : cr_q;
    c4       = {abs_cr[61:0], 2'b00};
    abs_x    = cx_q[43] ? -cx_q : cx_q;
    abs_y    = cy_q[43] ? -cy_q : cy_q;
    xs       = cx_q >>> it_q;
    ys       = cy_q >>> it_q;
    rz       = {cz_q[23], cz_q} + 25'sd64;
    rr       = rz[24:7];
    err_raw  = {{2{course_q[15]}}, course_q} - {{2{hd_q[15]}}, hd_q};
    if (err_raw > lpg_pkg::PI_Q) begin
      err_w = err_raw - lpg_pkg::TWO_PI_Q;
    end else if (err_raw < -lpg_pkg::PI_Q) begin
      err_w = err_raw + lpg_pkg::TWO_PI_Q;
    end else begin
      err_w = err_raw;
    end
    err_abs  = err_w[17] ? 16'(-err_w) : 16'(err_w);
    spd_fac  = $signed(lpg_pkg::HALF_PI_Q - err_abs);
    quo      = nz_q ? mres.p[59:44] : 16'd0;
    seg_skip = (l2_q == '0) || dot_q[62] || (dot_q > $signed({1'b0, l2_q}));
    more_seg = ((AW + 2)'(idx_q) + (AW + 2)'(2)) < (AW + 2)'(cnt_q);
  end

  always_comb begin
    mul_go  = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    mul_tag = lpg_pkg::T_NONE;
    unique case (state_q)
      S_R2: begin
        mul_go  = 1'b1;
        mul_a   = {2'b00, radius_q};
        mul_b   = {2'b00, radius_q};
        mul_tag = lpg_pkg::T_R2;
      end
      S_SEG: begin
        mul_go = (sc_q < 4'd6);
        case (sc_q)
          4'd0: begin
            mul_a = 33'(dx_q); mul_b = 33'(dx_q); mul_tag = lpg_pkg::T_L2S;
          end
          4'd1: begin
            mul_a = 33'(dy_q); mul_b = 33'(dy_q); mul_tag = lpg_pkg::T_L2A;
          end
          4'd2: begin
            mul_a = 33'(vx_q); mul_b = 33'(dx_q); mul_tag = lpg_pkg::T_DOTS;
          end
          4'd3: begin
            mul_a = 33'(vy_q); mul_b = 33'(dy_q); mul_tag = lpg_pkg::T_DOTA;
          end
          4'd4: begin
            mul_a = 33'(vx_q); mul_b = 33'(dy_q); mul_tag = lpg_pkg::T_CRS;
          end
          4'd5: begin
            mul_a = 33'(vy_q); mul_b = 33'(dx_q); mul_tag = lpg_pkg::T_CRB;
          end
          default: ;
        endcase
      end
      S_WIDE: begin
        mul_go = (sc_q < 4'd8);
        case (sc_q)
          4'd0: begin
            mul_a = {1'b0, c4[31:0]};  mul_b = {1'b0, c4[31:0]};
            mul_tag = lpg_pkg::T_WS0;
          end
          4'd1: begin
            mul_a = {1'b0, c4[31:0]};  mul_b = {1'b0, c4[63:32]};
            mul_tag = lpg_pkg::T_WS1;
          end
          4'd2: begin
            mul_a = {1'b0, c4[63:32]}; mul_b = {1'b0, c4[31:0]};
            mul_tag = lpg_pkg::T_WS1;
          end
          4'd3: begin
            mul_a = {1'b0, c4[63:32]}; mul_b = {1'b0, c4[63:32]};
            mul_tag = lpg_pkg::T_WS2;
          end
          4'd4: begin
            mul_a = {1'b0, r2_q[31:0]}; mul_b = {1'b0, l2_q[31:0]};
            mul_tag = lpg_pkg::T_WA0;
          end
          4'd5: begin
            mul_a = {1'b0, r2_q[31:0]}; mul_b = {3'b000, l2_q[61:32]};
            mul_tag = lpg_pkg::T_WA1;
          end
          4'd6: begin
            mul_a = {3'b000, r2_q[61:32]}; mul_b = {1'b0, l2_q[31:0]};
            mul_tag = lpg_pkg::T_WA1;
          end
          4'd7: begin
            mul_a = {3'b000, r2_q[61:32]}; mul_b = {3'b000, l2_q[61:32]};
            mul_tag = lpg_pkg::T_WA2;
          end
          default: ;
        endcase
      end
      S_SPD: begin
        mul_go  = 1'b1;
        mul_a   = {17'd0, maxs_q};
        mul_b   = 33'(spd_fac);
        mul_tag = lpg_pkg::T_RAW;
      end
      S_DIV: begin
        mul_go  = !mres.p[65] && (mres.p != '0);
        mul_a   = {1'b0, mres.p[31:0]};
        mul_b   = {1'b0, lpg_pkg::SPD_RECIP[31:0]};
        mul_tag = lpg_pkg::T_RAW;
      end
      default: ;
    endcase
  end

  always_comb begin
    case (mres.tag) inside
      lpg_pkg::T_WS1, lpg_pkg::T_WA1: wterm = 130'(mres.p[63:0]) << 32;
      lpg_pkg::T_WS2, lpg_pkg::T_WA2: wterm = 130'(mres.p[63:0]) << 64;
      default:                        wterm = 130'(mres.p[63:0]);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wa_clr) begin
      wa_q <= '0;
    end else if (mres.vld) begin
      case (mres.tag)
        lpg_pkg::T_R2:   r2_q  <= mres.p[61:0];
        lpg_pkg::T_L2S:  l2_q  <= mres.p[61:0];
        lpg_pkg::T_L2A:  l2_q  <= l2_q + mres.p[61:0];
        lpg_pkg::T_DOTS: dot_q <= mres.p[62:0];
        lpg_pkg::T_DOTA: dot_q <= dot_q + mres.p[62:0];
        lpg_pkg::T_CRS:  cr_q  <= mres.p[62:0];
        lpg_pkg::T_CRB:  cr_q  <= cr_q - mres.p[62:0];
        lpg_pkg::T_WS0, lpg_pkg::T_WS1, lpg_pkg::T_WS2: wa_q <= wa_q - $signed(wterm);
        lpg_pkg::T_WA0, lpg_pkg::T_WA1, lpg_pkg::T_WA2: wa_q <= wa_q + $signed(wterm);
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    sc_d     = sc_q;
    it_d     = it_q;
    found_d  = found_q;
    nz_d     = nz_q;
    done_d   = 1'b0;
    ax_d     = ax_q;
    ay_d     = ay_q;
    px_d     = px_q;
    py_d     = py_q;
    hd_d     = hd_q;
    dx_d     = dx_q;
    dy_d     = dy_q;
    vx_d     = vx_q;
    vy_d     = vy_q;
    cx_d     = cx_q;
    cy_d     = cy_q;
    cz_d     = cz_q;
    course_d = course_q;
    spd_d    = spd_q;
    ocrs_d   = ocrs_q;
    oempty_d = oempty_q;
    ofound_d = ofound_q;
    wa_clr   = 1'b0;
    ram_we   = 1'b0;
    ram_waddr = AW'(cnt_q);
    ram_re   = 1'b0;
    ram_raddr = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          px_d = pos_x_i;
          py_d = pos_y_i;
          hd_d = heading_i;
          if (command_i == lpg_pkg::CMD_POSE) begin
            if (cnt_q < CW'(2)) begin
              done_d   = 1'b1;
              spd_d    = '0;
              ocrs_d   = heading_i;
              oempty_d = 1'b1;
              ofound_d = 1'b0;
            end else begin
              state_d = S_R2;
            end
          end else if (restart_path_i) begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            cnt_d     = CW'(1);
          end else if (cnt_q < CW'(MAX_POINTS)) begin
            ram_we = 1'b1;
            cnt_d  = cnt_q + CW'(1);
          end
        end
      end
      S_R2: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
        found_d   = 1'b0;
        state_d   = S_LDA;
      end
      S_LDA: begin
        ax_d      = rd_x;
        ay_d      = rd_y;
        ram_re    = 1'b1;
        ram_raddr = AW'(1);
        idx_d     = '0;
        state_d   = S_LDB;
      end
      S_LDB: begin
        dx_d    = dfx[32:2];
        dy_d    = dfy[32:2];
        vx_d    = dvx[32:2];
        vy_d    = dvy[32:2];
        sc_d    = '0;
        state_d = S_SEG;
      end
      S_SEG: begin
        sc_d = sc_q + 4'd1;
        if (sc_q == 4'd6) begin
          state_d = S_CHK;
        end
      end
      S_CHK, S_WCHK: begin
        if (state_q == S_CHK && !seg_skip) begin
          wa_clr  = 1'b1;
          sc_d    = '0;
          state_d = S_WIDE;
        end else if (state_q == S_WCHK && !wa_q[129]) begin
          found_d = 1'b1;
          if (cr_q > 0) begin
            cx_d = -44'(dy_q);
            cy_d = 44'(dx_q);
          end else if (cr_q < 0) begin
            cx_d = 44'(dy_q);
            cy_d = -44'(dx_q);
          end else begin
            cx_d = '0;
            cy_d = '0;
          end
          state_d = S_ANORM;
        end else if (more_seg) begin
          ax_d      = rd_x;
          ay_d      = rd_y;
          idx_d     = idx_q + AW'(1);
          ram_re    = 1'b1;
          ram_raddr = idx_q + AW'(2);
          state_d   = S_LDB;
        end else begin
          cx_d    = 44'(tgx);
          cy_d    = 44'(tgy);
          state_d = S_ANORM;
        end
      end
      S_WIDE: begin
        sc_d = sc_q + 4'd1;
        if (sc_q == 4'd8) begin
          state_d = S_WCHK;
        end
      end
      S_ANORM: begin
        if (cx_q == '0 && cy_q == '0) begin
          course_d = '0;
          state_d  = S_SPD;
        end else if (abs_x[43:40] == 4'd0 && abs_y[43:40] == 4'd0) begin
          cx_d = cx_q <<< 1;
          cy_d = cy_q <<< 1;
        end else begin
          it_d    = '0;
          state_d = S_CORD;
          if (cx_q < 0) begin
            if (cy_q >= 0) begin
              cx_d = cy_q;
              cy_d = -cx_q;
              cz_d = lpg_pkg::ATAN0_X2;
            end else begin
              cx_d = -cy_q;
              cy_d = cx_q;
              cz_d = -lpg_pkg::ATAN0_X2;
            end
          end else begin
            cz_d = '0;
          end
        end
      end
      S_CORD: begin
        if (cy_q > 0) begin
          cx_d = cx_q + ys;
          cy_d = cy_q - xs;
          cz_d = cz_q + $signed({2'b00, lpg_pkg::cordic_atan(it_q)});
        end else begin
          cx_d = cx_q - ys;
          cy_d = cy_q + xs;
          cz_d = cz_q - $signed({2'b00, lpg_pkg::cordic_atan(it_q)});
        end
        it_d = it_q + 5'd1;
        if (it_q == 5'(lpg_pkg::CORDIC_STEPS - 1)) begin
          state_d = S_RND;
        end
      end
      S_RND: begin
        if (rr > lpg_pkg::PI_Q) begin
          course_d = 16'(lpg_pkg::PI_Q);
        end else if (rr < -lpg_pkg::PI_Q) begin
          course_d = 16'(-lpg_pkg::PI_Q);
        end else begin
          course_d = rr[15:0];
        end
        state_d = S_SPD;
      end
      S_SPD: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        nz_d    = !mres.p[65] && (mres.p != '0);
        state_d = S_FIN;
      end
      S_FIN: begin
        done_d   = 1'b1;
        spd_d    = (quo < mins_q) ? mins_q : quo;
        ocrs_d   = course_q;
        oempty_d = 1'b0;
        ofound_d = found_q;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      idx_q    <= '0;
      sc_q     <= '0;
      it_q     <= '0;
      found_q  <= 1'b0;
      nz_q     <= 1'b0;
      done_q   <= 1'b0;
      radius_q <= 31'd327680;
      maxs_q   <= 16'd512;
      mins_q   <= 16'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      sc_q    <= sc_d;
      it_q    <= it_d;
      found_q <= found_d;
      nz_q    <= nz_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          lpg_pkg::CFG_RADIUS:    radius_q <= cfg_data_i;
          lpg_pkg::CFG_MAX_SPEED: maxs_q   <= cfg_data_i[15:0];
          lpg_pkg::CFG_MIN_SPEED: mins_q   <= cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q     <= ax_d;
    ay_q     <= ay_d;
    px_q     <= px_d;
    py_q     <= py_d;
    hd_q     <= hd_d;
    dx_q     <= dx_d;
    dy_q     <= dy_d;
    vx_q     <= vx_d;
    vy_q     <= vy_d;
    cx_q     <= cx_d;
    cy_q     <= cy_d;
    cz_q     <= cz_d;
    course_q <= course_d;
    spd_q    <= spd_d;
    ocrs_q   <= ocrs_d;
    oempty_q <= oempty_d;
    ofound_q <= ofound_d;
  end

  assign done_o       = done_q;
  assign speed_o      = spd_q;
  assign course_o     = ocrs_q;
  assign path_empty_o = oempty_q;
  assign seg_found_o  = ofound_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result strobe while busy");
  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_POINTS)) else $error("point count over capacity");
  a_cord_it: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CORD |-> it_q < 5'(lpg_pkg::CORDIC_STEPS))
    else $error("CORDIC step overrun");
  a_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && path_empty_o |-> speed_o == 16'd0 && !seg_found_o)
    else $error("short path result not idle");
  a_wide_l2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WIDE |-> l2_q != '0) else $error("zero-length segment tested");
endmodule
`default_nettype wire

// ===== test/los_path_guidance_test.sv =====
// Self-checking testbench for the line-of-sight path guidance block.
`timescale 1ns / 100ps
module los_path_guidance_test;

  localparam int unsigned MAX_POINTS = 64;
  localparam int unsigned STALL_LIMIT = 20000;

  typedef struct {
    logic [15:0]        speed;
    logic signed [15:0] course;
    logic               path_empty;
    logic               found;
  } guidance_t;

  class guidance_scoreboard;
    longint     wp_x[MAX_POINTS];
    longint     wp_y[MAX_POINTS];
    int         point_count;
    longint     radius, max_spd, min_spd;
    guidance_t  expected_q[$];
    int         errors;

    function void clear();
      point_count = 0;
      radius = 327680;
      max_spd = 512;
      min_spd = 0;
      errors = 0;
    endfunction

    function void set_reg(lpg_pkg::cfg_idx_e idx, logic [30:0] value);
      case (idx)
        lpg_pkg::CFG_RADIUS:    radius = longint'(value);
        lpg_pkg::CFG_MAX_SPEED: max_spd = longint'(value[15:0]);
        lpg_pkg::CFG_MIN_SPEED: min_spd = longint'(value[15:0]);
        default: ;
      endcase
    endfunction

    function longint atan2_q13(longint y, longint x);
      longint angle_tab[20] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383,
                                8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
      longint z, m, t, xs, ys, r;
      z = 0;
      if (x == 0 && y == 0) return 0;
      m = (x < 0 ? -x : x) > (y < 0 ? -y : y) ? (x < 0 ? -x : x) : (y < 0 ? -y : y);
      while (m < (64'sd1 <<< 40)) begin
        x = x * 2;
        y = y * 2;
        m = m * 2;
      end
      if (x < 0) begin
        t = x;
        if (y >= 0) begin
          x = y; y = -t; z = angle_tab[0] * 2;
        end else begin
          x = -y; y = t; z = -angle_tab[0] * 2;
        end
      end
      for (int i = 0; i < 20; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x += ys; y -= xs; z += angle_tab[i];
        end else begin
          x -= ys; y += xs; z -= angle_tab[i];
        end
      end
      r = (z + 64) >>> 7;
      if (r > 25736) r = 25736;
      if (r < -25736) r = -25736;
      return r;
    endfunction

    function void note_request(lpg_pkg::cmd_e cmd, logic restart, logic signed [31:0] px_in,
                               logic signed [31:0] py_in, logic signed [15:0] hd_in);
      longint px, py, hd, dx, dy, vx, vy, l2, dot, cr, tx, ty, crs, err, num, spd;
      logic [127:0] lhs, rhs;
      guidance_t g;
      bit found;
      px = px_in; py = py_in; hd = hd_in;
      found = 0; tx = 0; ty = 0;
      if (cmd == lpg_pkg::CMD_LOAD) begin
        if (restart) point_count = 0;
        if (point_count < MAX_POINTS) begin
          wp_x[point_count] = px;
          wp_y[point_count] = py;
          point_count++;
        end
        return;
      end
      if (point_count < 2) begin
        g = '{16'd0, hd_in, 1'b1, 1'b0};
        expected_q.push_back(g);
        return;
      end
      for (int i = 0; i + 1 < point_count && !found; i++) begin
        dx = (wp_x[i+1] - wp_x[i]) >>> 2;
        dy = (wp_y[i+1] - wp_y[i]) >>> 2;
        vx = (px - wp_x[i]) >>> 2;
        vy = (py - wp_y[i]) >>> 2;
        l2 = dx * dx + dy * dy;
        dot = vx * dx + vy * dy;
        cr = vx * dy - vy * dx;
        if (l2 == 0 || dot < 0 || dot > l2) continue;
        crs = (cr < 0 ? -cr : cr) * 4;
        lhs = 128'(crs) * 128'(crs);
        rhs = 128'(radius * radius) * 128'(l2);
        if (lhs <= rhs) begin
          found = 1;
          if (cr > 0) begin
            tx = -dy; ty = dx;
          end else if (cr < 0) begin
            tx = dy; ty = -dx;
          end
        end
      end
      if (!found) begin
        tx = wp_x[point_count-1] - px;
        ty = wp_y[point_count-1] - py;
      end
      g.course = 16'(atan2_q13(ty, tx));
      err = longint'(g.course) - hd;
      while (err > 25736) err -= 51472;
      while (err < -25736) err += 51472;
      num = max_spd * (12868 - (err < 0 ? -err : err));
      spd = num > 0 ? num / 12868 : 0;
      if (spd < min_spd) spd = min_spd;
      g.speed = 16'(spd);
      g.path_empty = 1'b0;
      g.found = found;
      expected_q.push_back(g);
    endfunction

    task report(string what, longint got, longint want);
      errors++;
      $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
    endtask

    task check_result(guidance_t r);
      guidance_t e;
      if (expected_q.size() == 0) begin
        report("unexpected result, speed", r.speed, 0);
        return;
      end
      e = expected_q.pop_front();
      if (r.speed !== e.speed) report("speed", r.speed, e.speed);
      if (r.course !== e.course) report("course", r.course, e.course);
      if (r.path_empty !== e.path_empty) report("path_empty", r.path_empty, e.path_empty);
      if (r.found !== e.found) report("seg_found", r.found, e.found);
    endtask
  endclass

  logic clk_i, rst_ni, start, busy;
  logic command_i, restart_path_i;
  logic signed [31:0] pos_x_i, pos_y_i;
  logic signed [15:0] heading_i;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [30:0] cfg_data_i;
  logic done_o, path_empty_o, seg_found_o;
  logic [15:0] speed_o;
  logic signed [15:0] course_o;

  guidance_scoreboard sb;
  bit idle_on;
  int stall_cycles = 0;

  los_path_guidance #(.MAX_POINTS(MAX_POINTS)) DUT (.*);

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (done_o) sb.check_result('{speed_o, course_o, path_empty_o, seg_found_o});
    if ((start && !busy) || done_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task send_request(lpg_pkg::cmd_e cmd, logic restart, logic signed [31:0] x,
                    logic signed [31:0] y, logic signed [15:0] hd);
    while (idle_on && $urandom_range(99) < 23) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    command_i <= cmd;
    restart_path_i <= restart;
    pos_x_i <= x;
    pos_y_i <= y;
    heading_i <= hd;
    do @(posedge clk_i); while (busy);
    sb.note_request(cmd, restart, x, y, hd);
  endtask

  task write_regs(logic [30:0] radius, logic [15:0] vmax, logic [15:0] vmin);
    start <= 1'b0;
    while (sb.expected_q.size() != 0 || busy) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= lpg_pkg::CFG_RADIUS; cfg_data_i <= radius;
    @(posedge clk_i);
    sb.set_reg(lpg_pkg::CFG_RADIUS, radius);
    cfg_idx_i <= lpg_pkg::CFG_MAX_SPEED; cfg_data_i <= 31'(vmax);
    @(posedge clk_i);
    sb.set_reg(lpg_pkg::CFG_MAX_SPEED, 31'(vmax));
    cfg_idx_i <= lpg_pkg::CFG_MIN_SPEED; cfg_data_i <= 31'(vmin);
    @(posedge clk_i);
    sb.set_reg(lpg_pkg::CFG_MIN_SPEED, 31'(vmin));
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic signed [31:0] near_coord(int span_m);
    return $signed(32'($urandom_range(0, 2 * span_m * 65536))) - span_m * 65536;
  endfunction

  function automatic logic signed [15:0] rand_heading();
    if ($urandom_range(9) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 51472)) - 16'sd25736;
  endfunction

  task random_path_phase(int n_items);
    int sent, n_pts;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        send_request(lpg_pkg::cmd_e'($urandom_range(1)), 1'($urandom), 32'($urandom),
                     32'($urandom), 16'($urandom));
        sent++;
      end else begin
        n_pts = $urandom_range(0, 6);
        for (int i = 0; i < n_pts; i++) begin
          send_request(lpg_pkg::CMD_LOAD, i == 0, near_coord(40), near_coord(40),
                       16'($urandom));
          sent++;
        end
        for (int i = $urandom_range(1, 4); i > 0; i--) begin
          send_request(lpg_pkg::CMD_POSE, 1'($urandom), near_coord(45), near_coord(45),
                       rand_heading());
          sent++;
        end
      end
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    rst_ni = 0; start = 0; command_i = 0; restart_path_i = 0;
    pos_x_i = 0; pos_y_i = 0; heading_i = 0;
    cfg_we_i = 0; cfg_idx_i = lpg_pkg::CFG_RADIUS; cfg_data_i = 0;
    idle_on = 1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // short path, then a basic segment
    send_request(lpg_pkg::CMD_POSE, 1'b0, 32'sh7FFFFFFF, 32'sh80000000, -16'sd25736);
    send_request(lpg_pkg::CMD_LOAD, 1'b1, 0, 0, 0);
    send_request(lpg_pkg::CMD_POSE, 1'b0, 0, 0, 16'sh7FFF);
    send_request(lpg_pkg::CMD_LOAD, 1'b0, 32'sd10 <<< 16, 0, 0);
    send_request(lpg_pkg::CMD_POSE, 1'b0, 32'sd5 <<< 16, 32'sd2 <<< 16, 16'sd25736);
    send_request(lpg_pkg::CMD_POSE, 1'b0, 32'sd5 <<< 16, -(32'sd2 <<< 16), 16'sh8000);
    send_request(lpg_pkg::CMD_POSE, 1'b0, 32'sd5 <<< 16, 0, 0);
    send_request(lpg_pkg::CMD_POSE, 1'b0, 32'sd5 <<< 16, 32'sd40 <<< 16, 16'sd12868);
    // zero-length segment followed by a real one
    send_request(lpg_pkg::CMD_LOAD, 1'b1, 32'sd3 <<< 16, 32'sd3 <<< 16, 0);
    send_request(lpg_pkg::CMD_LOAD, 1'b0, 32'sd3 <<< 16, 32'sd3 <<< 16, 0);
    send_request(lpg_pkg::CMD_LOAD, 1'b0, 32'sd3 <<< 16, 32'sd9 <<< 16, 0);
    send_request(lpg_pkg::CMD_POSE, 1'b0, 32'sd4 <<< 16, 32'sd5 <<< 16, -16'sd100);
    send_request(lpg_pkg::CMD_POSE, 1'b0, 32'sd3 <<< 16, 32'sd3 <<< 16, 0);
    // extreme coordinates
    send_request(lpg_pkg::CMD_LOAD, 1'b1, 32'sh80000000, 32'sh80000000, 0);
    send_request(lpg_pkg::CMD_LOAD, 1'b0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0);
    send_request(lpg_pkg::CMD_POSE, 1'b0, 0, 0, 0);
    send_request(lpg_pkg::CMD_POSE, 1'b0, 32'sh7FFFFFFF, 32'sh80000000, -16'sd25736);
    send_request(lpg_pkg::CMD_POSE, 1'b0, 32'sh80000000, 32'sh7FFFFFFF, 16'sd25736);

    write_regs(31'd0, 16'hFFFF, 16'd0);
    // full path: loads past capacity are dropped
    for (int i = 0; i < MAX_POINTS + 3; i++)
      send_request(lpg_pkg::CMD_LOAD, i == 0, near_coord(200), near_coord(200), 0);
    for (int i = 0; i < 3; i++)
      send_request(lpg_pkg::CMD_POSE, 1'b0, near_coord(200), near_coord(200), rand_heading());
    random_path_phase(10);

    write_regs(31'h7FFFFFFF, 16'd0, 16'hFFFF);
    random_path_phase(6);

    write_regs(31'($urandom_range(0, 20 << 16)), 16'($urandom), 16'($urandom_range(0, 300)));
    idle_on = 0;
    random_path_phase(16);
    idle_on = 1;

    write_regs(31'($urandom), 16'($urandom), 16'($urandom_range(0, 100)));
    random_path_phase(8);

    start <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
